// File: rtl/core/rlec_pkg.sv
// Package for the run-length escape compressor.
// Holds the run command type, queue sizing and shared constants.
// No dependencies.
package rlec_pkg;

  localparam logic [7:0] EscapeByte   = 8'hFF;
  localparam logic [7:0] LiteralLimit = 8'd3;

  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  // One closed run, ready to be expanded into compressed bytes.
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] length;
    logic       esc;
    logic       item_last;
    logic       block_end;
  } rlec_cmd_t;

  // Up to two run commands pushed by the front in one cycle.
  typedef struct packed {
    logic      push0;
    logic      push1;
    rlec_cmd_t cmd0;
    rlec_cmd_t cmd1;
  } rlec_push_t;

  function automatic logic rlec_needs_esc(logic [7:0] length, logic [7:0] value);
    rlec_needs_esc = (length > LiteralLimit) || (value == EscapeByte);
  endfunction

endpackage

// File: rtl/core/rlec_if.sv
// Handshake interfaces for the run-length escape compressor channels.
// Input request carries one raw byte; output request carries one compressed byte.
// No dependencies.
interface rlec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_last;

  modport source (output valid, output data_byte, output block_last, input ready);
  modport sink   (input valid, input data_byte, input block_last, output ready);
endinterface

interface rlec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       item_last;
  logic       block_end;

  modport source (output valid, output out_byte, output item_last, output block_end,
                  input ready);
  modport sink   (input valid, input out_byte, input item_last, input block_end,
                  output ready);
endinterface

// File: rtl/core/rle_escape_compressor_core.sv
// Run-length escape compressor, top level. With an empty queue, the first compressed byte of a
// closing request passes through the command queue and the output register. Throughput: one
// request per cycle while the command queue holds at most two entries; the output side emits
// one byte per cycle while the receiver is ready, three for an escaped run. Reset clears the
// open run and the queue. Depends on rlec_pkg, rlec_if, rlec_front, rlec_cmd_fifo and rlec_back.
module rle_escape_compressor_core
  import rlec_pkg::*;
#(
  parameter int unsigned MAX_RUN = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlec_in_if.sink    in_i,
  rlec_out_if.source out_o
);

  rlec_push_t push;
  logic       space;
  logic       head_valid;
  rlec_cmd_t  head;
  logic       pop;

  rlec_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .space_i (space),
    .push_o  (push)
  );

  rlec_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .space_o      (space),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  rlec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.block_end |-> out_o.item_last)
    else $error("block end without item last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid |-> head.length != 8'd0)
    else $error("empty run command queued");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !space |-> head_valid)
    else $error("queue full while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push1 |-> push.push0)
    else $error("second push without first");

endmodule

// File: rtl/core/rlec_front.sv
// Front end of the compressor: tracks the open run and turns each request
// into zero, one or two run commands. Depends on rlec_pkg and rlec_in_if.
module rlec_front
  import rlec_pkg::*;
#(
  parameter int unsigned MAX_RUN = 255
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rlec_in_if.sink      in_i,
  input  logic         space_i,
  output rlec_push_t   push_o
);

  localparam logic [7:0] RunMax = 8'(MAX_RUN);

  logic [7:0] run_value_q, run_value_d;
  logic [7:0] run_length_q, run_length_d;
  logic       accept;
  logic       close_run;
  logic [7:0] new_value;
  logic [7:0] new_length;
  rlec_cmd_t  cmd_old;
  rlec_cmd_t  cmd_cur;

  assign in_i.ready = space_i;
  assign accept     = in_i.valid && space_i;

  assign close_run = !((run_length_q != 8'd0) && (in_i.data_byte == run_value_q) &&
                       (run_length_q < RunMax));

  assign new_value  = close_run ? in_i.data_byte : run_value_q;
  assign new_length = close_run ? 8'd1 : run_length_q + 8'd1;

  always_comb begin
    cmd_old.value     = run_value_q;
    cmd_old.length    = run_length_q;
    cmd_old.esc       = rlec_needs_esc(run_length_q, run_value_q);
    cmd_old.item_last = !in_i.block_last;
    cmd_old.block_end = 1'b0;

    cmd_cur.value     = new_value;
    cmd_cur.length    = new_length;
    cmd_cur.esc       = rlec_needs_esc(new_length, new_value);
    cmd_cur.item_last = 1'b1;
    cmd_cur.block_end = 1'b1;
  end

  // The run that closes goes first; the end-of-block flush follows it.
  always_comb begin
    logic emit_old;
    emit_old      = close_run && (run_length_q != 8'd0);
    push_o.push0  = accept && (emit_old || in_i.block_last);
    push_o.push1  = accept && emit_old && in_i.block_last;
    push_o.cmd0   = emit_old ? cmd_old : cmd_cur;
    push_o.cmd1   = cmd_cur;
  end

  always_comb begin
    run_value_d  = run_value_q;
    run_length_d = run_length_q;
    if (accept) begin
      run_value_d  = new_value;
      run_length_d = in_i.block_last ? 8'd0 : new_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q  <= 8'd0;
      run_length_q <= 8'd0;
    end else begin
      run_value_q  <= run_value_d;
      run_length_q <= run_length_d;
    end
  end

endmodule

// File: rtl/core/rlec_cmd_fifo.sv
// Short queue of run commands between the front and back ends.
// Takes up to two commands per cycle and hands out one. Depends on rlec_pkg.
module rlec_cmd_fifo
  import rlec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rlec_push_t push_i,
  output logic       space_o,
  output logic       head_valid_o,
  output rlec_cmd_t  head_o,
  input  logic       pop_i
);

  rlec_cmd_t            mem_q [CmdDepth];
  logic [CmdPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CmdCntW-1:0]   count_q, count_d;
  logic [CmdPtrW-1:0]   wr_ptr_next;
  logic [CmdCntW-1:0]   n_push;

  assign space_o      = count_q <= CmdCntW'(CmdDepth - 2);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign wr_ptr_next  = wr_ptr_q + CmdPtrW'(1);

  assign n_push = CmdCntW'(push_i.push0) + CmdCntW'(push_i.push1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + CmdPtrW'(n_push);
    rd_ptr_d = rd_ptr_q + CmdPtrW'(pop_i);
    count_d  = count_q + n_push - CmdCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= push_i.cmd0;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr_next] <= push_i.cmd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: rtl/core/rlec_back.sv
// Back end of the compressor: expands each run command into literal bytes or
// an escape, count, value triple. Depends on rlec_pkg and rlec_out_if.
module rlec_back
  import rlec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  rlec_cmd_t   head_i,
  output logic        pop_o,
  rlec_out_if.source  out_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       item_last_q;
  logic       block_end_q;
  logic       load;
  logic       last_byte;
  logic [7:0] next_byte;

  assign load = head_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    if (head_i.esc) begin
      last_byte = idx_q == 2'd2;
      case (idx_q)
        2'd0:    next_byte = EscapeByte;
        2'd1:    next_byte = head_i.length;
        default: next_byte = head_i.value;
      endcase
    end else begin
      last_byte = {6'd0, idx_q} + 8'd1 == head_i.length;
      next_byte = head_i.value;
    end
  end

  assign pop_o = load && last_byte;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last_byte ? 2'd0 : idx_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q  <= next_byte;
      item_last_q <= last_byte && head_i.item_last;
      block_end_q <= last_byte && head_i.block_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.item_last = item_last_q;
  assign out_o.block_end = block_end_q;

endmodule

// File: dv/tb.sv
// Testbench for rle_escape_compressor_core: drives raw bytes and checks the compressed stream.
// A run-length encoder kept in step with the accepted requests predicts every output byte.
// Depends on rlec_pkg, rlec_if and the compressor RTL.
module tb;
  import rlec_pkg::*;

  localparam int unsigned RunMax      = 255;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomItems = 90;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       item_last;
    logic       block_end;
  } code_byte_t;

  typedef enum logic [1:0] {
    RxFree,
    RxCoin,
    RxThird,
    RxRare
  } rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rlec_in_if  raw_if ();
  rlec_out_if code_if ();

  rle_escape_compressor_core #(
    .MAX_RUN(RunMax)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (raw_if),
    .out_o (code_if)
  );

  always #5 clk_i = ~clk_i;

  code_byte_t  pending_codes[$];
  code_byte_t  step_codes[$];
  logic [7:0]  run_val;
  logic [7:0]  run_len;
  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  logic        tx_steady   = 1'b0;
  logic        hold_req    = 1'b0;

  function automatic code_byte_t plain_code(input logic [7:0] b);
    code_byte_t c;
    c.out_byte  = b;
    c.item_last = 1'b0;
    c.block_end = 1'b0;
    return c;
  endfunction

  function automatic void close_run();
    int unsigned k;
    if (run_len == 8'd0) return;
    if (run_len > LiteralLimit || run_val == EscapeByte) begin
      step_codes = {step_codes, plain_code(EscapeByte)};
      step_codes = {step_codes, plain_code(run_len)};
      step_codes = {step_codes, plain_code(run_val)};
    end else begin
      for (k = 0; k < run_len; k++) step_codes = {step_codes, plain_code(run_val)};
    end
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic last);
    int unsigned n;
    step_codes.delete();
    if (run_len != 8'd0 && b == run_val && run_len < RunMax) begin
      run_len = run_len + 8'd1;
    end else begin
      close_run();
      run_val = b;
      run_len = 8'd1;
    end
    if (last) begin
      close_run();
      run_len = 8'd0;
    end
    n = step_codes.size();
    if (n > 0) begin
      step_codes[n - 1].item_last = 1'b1;
      step_codes[n - 1].block_end = last;
    end
    pending_codes = {pending_codes, step_codes};
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %02h, expected %02h", field, got, want);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last);
    raw_if.valid      <= 1'b1;
    raw_if.data_byte  <= data;
    raw_if.block_last <= last;
    do @(posedge clk_i); while (!raw_if.ready);
    encode_byte(data, last);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (!tx_steady) begin
      raw_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  always @(posedge clk_i) begin : check_codes
    code_byte_t want;
    if (rst_ni && code_if.valid && code_if.ready) begin
      if (pending_codes.size() == 0) begin
        report_mismatch("unexpected byte", code_if.out_byte, 8'h00);
      end else begin
        want = pending_codes.pop_front();
        if (code_if.out_byte !== want.out_byte)
          report_mismatch("out_byte", code_if.out_byte, want.out_byte);
        if (code_if.item_last !== want.item_last)
          report_mismatch("item_last", 8'(code_if.item_last), 8'(want.item_last));
        if (code_if.block_end !== want.block_end)
          report_mismatch("block_end", 8'(code_if.block_end), 8'(want.block_end));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((raw_if.valid && raw_if.ready) || (code_if.valid && code_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : rx_stall
    rx_mode_e    mode;
    int unsigned left;
    int unsigned phase;
    mode = RxFree;
    left = 0;
    phase = 0;
    code_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        code_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode  = rx_mode_e'($urandom_range(0, 3));
          left  = $urandom_range(10, 60);
          phase = 0;
        end
        left--;
        phase++;
        case (mode)
          RxFree:  code_if.ready <= 1'b1;
          RxCoin:  code_if.ready <= ($urandom_range(0, 1) == 1);
          RxThird: code_if.ready <= (phase % 3 == 0);
          default: code_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic test_directed_runs();
    int unsigned k;
    send_byte(8'h00, 1'b1);
    send_byte(EscapeByte, 1'b1);
    for (k = 0; k < 3; k++) send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    for (k = 0; k < 4; k++) send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    for (k = 0; k < 2; k++) send_byte(EscapeByte, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_run_limit();
    int unsigned k;
    for (k = 0; k < RunMax; k++) send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_output_hold();
    int unsigned k;
    tx_steady = 1'b1;
    hold_req  = 1'b1;
    for (k = 0; k < 40; k++) send_byte((k % 2 == 0) ? 8'h11 : EscapeByte, (k % 10) == 9);
    tx_steady = 1'b0;
  endtask

  task automatic test_random_stream();
    int unsigned stop_at;
    int unsigned n_runs;
    int unsigned len;
    int unsigned r;
    int unsigned k;
    logic [7:0]  v;
    stop_at = items_sent + RandomItems;
    v = 8'h00;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) send_byte(8'($urandom()), $urandom_range(0, 7) == 0);
      end else begin
        n_runs = $urandom_range(1, 6);
        for (r = 0; r < n_runs; r++) begin
          case ($urandom_range(0, 3))
            0:       v = EscapeByte;
            1:       v = v;
            default: v = 8'($urandom());
          endcase
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 4);
          for (k = 0; k < len; k++) send_byte(v, (r == n_runs - 1) && (k == len - 1));
        end
      end
    end
  endtask

  initial begin
    raw_if.valid      = 1'b0;
    raw_if.data_byte  = 8'h00;
    raw_if.block_last = 1'b0;
    run_val = 8'h00;
    run_len = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_runs();
    test_run_limit();
    test_output_hold();
    test_random_stream();
    raw_if.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
